/* src/w2a_pkg.sv */
// ----------------------------------------------------------------------------
// w2a_pkg
// Shared types, character codes and helpers of the word to ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package w2a_pkg;

   localparam int WORD_W  = 32;
   localparam int FMT_W   = 3;
   localparam int CHAR_W  = 8;
   localparam int NUM_DEC = 10;               // decimal digits of a 32-bit word
   localparam int BCD_W   = 4 * NUM_DEC;      // digit shift register width
   localparam int CNT_W   = 6;                // holds up to WORD_W digits
   localparam int STEP_W  = 5;                // conversion steps, WORD_W - 1 .. 0

   // format codes
   localparam logic [FMT_W-1:0] FMT_BIN  = 3'd0;
   localparam logic [FMT_W-1:0] FMT_SDEC = 3'd1;
   localparam logic [FMT_W-1:0] FMT_HEX  = 3'd2;
   localparam logic [FMT_W-1:0] FMT_UDEC = 3'd3;
   localparam logic [FMT_W-1:0] FMT_SWAP = 3'd4;

   // characters
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;

   typedef struct packed {
      logic [WORD_W-1:0] word_value;
      logic [FMT_W-1:0]  format_code;
   } req_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              is_last;
   } rsp_item_type;

   // operation of the shared shift unit
   typedef enum logic [1:0] {
      SHM_DABBLE = 2'd0,   // add-3 adjust, then shift {digits, binary} left one
      SHM_ONE    = 2'd1,   // drop one binary digit
      SHM_FOUR   = 2'd2    // drop one nibble digit
   } shift_mode_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + CHAR_W'(d);
      end else begin
         c = CH_LOW_A + CHAR_W'(d - 4'd10);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/w2a_shift_unit.sv */
// ----------------------------------------------------------------------------
// w2a_shift_unit
// Shared shifter: one double-dabble step, or one digit shifted out of the top.
// ----------------------------------------------------------------------------
`default_nettype none

module w2a_shift_unit (
   input  w2a_pkg::shift_mode_type      mode,
   input  logic [w2a_pkg::BCD_W-1:0]    digits,
   input  logic [w2a_pkg::WORD_W-1:0]   binary,
   output logic [w2a_pkg::BCD_W-1:0]    digits_next,
   output logic [w2a_pkg::WORD_W-1:0]   binary_next
);
   import w2a_pkg::*;

   logic [BCD_W-1:0] adjusted;

   // add 3 to every BCD digit of 5 or more
   always_comb begin
      for (int i = 0; i < NUM_DEC; i++) begin
         if (digits[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = digits[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = digits[4*i +: 4];
         end
      end
   end

   always_comb begin
      case (mode)
         SHM_DABBLE: begin
            digits_next = {adjusted[BCD_W-2:0], binary[WORD_W-1]};
            binary_next = {binary[WORD_W-2:0], 1'b0};
         end
         SHM_ONE: begin
            digits_next = {digits[BCD_W-2:0], 1'b0};
            binary_next = binary;
         end
         SHM_FOUR: begin
            digits_next = {digits[BCD_W-5:0], 4'd0};
            binary_next = binary;
         end
         default: begin
            digits_next = digits;
            binary_next = binary;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/word_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// word_to_ascii_formatter_unit
// Formats a 32-bit word as binary, hex, signed or unsigned decimal, or byte-swapped
// decimal ASCII text, one character per item, closed by a newline flagged last.
// ----------------------------------------------------------------------------
// Sequence: decimal formats first run the double-dabble conversion, then a '-'
//   for a negative signed word; binary and hex emit their prefix at once. Leading
//   zero digits are then stripped, keeping at least one, and the digits emitted.
// Words are taken one at a time; a new word is taken only once the newline of
//   the last one has been emitted.
// Reset: synchronous, active high; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module word_to_ascii_formatter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  w2a_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output w2a_pkg::rsp_item_type rsp_item
);
   import w2a_pkg::*;

   // one-hot sequencer
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,   // waiting for a word
      ST_CONV  = 6'b000010,   // binary to BCD, one bit per cycle
      ST_PRE   = 6'b000100,   // "0b", "0x" or '-'
      ST_SKIP  = 6'b001000,   // strip leading zero digits
      ST_DIGIT = 6'b010000,   // emit digits, most significant first
      ST_NL    = 6'b100000    // closing newline
   } state_type;

   state_type         state_ff, state_in;
   logic [BCD_W-1:0]  sr_ff, sr_in;       // digits, top-aligned
   logic [WORD_W-1:0] bin_ff, bin_in;     // value still to be converted
   logic [CNT_W-1:0]  cnt_ff, cnt_in;     // digits left in sr
   logic [STEP_W-1:0] step_ff, step_in;   // conversion steps left
   logic              wide_ff, wide_in;   // 4-bit digits (hex, decimal)
   logic              neg_ff, neg_in;     // signed and negative
   logic              pre_two_ff, pre_two_in;
   logic              pre_idx_ff, pre_idx_in;
   logic [CHAR_W-1:0] pre0_ff, pre0_in;
   logic [CHAR_W-1:0] pre1_ff, pre1_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   shift_mode_type    mode;
   logic [BCD_W-1:0]  sr_next;
   logic [WORD_W-1:0] bin_next;
   logic [3:0]        top_digit;
   logic              accept;
   logic              out_free;
   logic              emit;
   rsp_item_type      emit_item;
   logic [WORD_W-1:0] abs_word;
   logic [WORD_W-1:0] swap_word;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign top_digit = wide_ff ? sr_ff[BCD_W-1 -: 4] : {3'd0, sr_ff[BCD_W-1]};
   assign mode      = (state_ff == ST_CONV) ? SHM_DABBLE :
                      (wide_ff ? SHM_FOUR : SHM_ONE);

   assign abs_word  = req_item.word_value[WORD_W-1] ?
                      (WORD_W'(0) - req_item.word_value) : req_item.word_value;
   assign swap_word = {req_item.word_value[7:0],   req_item.word_value[15:8],
                       req_item.word_value[23:16], req_item.word_value[31:24]};

   w2a_shift_unit u_shift (
      .mode        (mode),
      .digits      (sr_ff),
      .binary      (bin_ff),
      .digits_next (sr_next),
      .binary_next (bin_next)
   );

   always_comb begin
      state_in   = state_ff;
      sr_in      = sr_ff;
      bin_in     = bin_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      wide_in    = wide_ff;
      neg_in     = neg_ff;
      pre_two_in = pre_two_ff;
      pre_idx_in = pre_idx_ff;
      pre0_in    = pre0_ff;
      pre1_in    = pre1_ff;
      emit       = 1'b0;
      emit_item  = '{text_char: CH_NL, is_last: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pre_idx_in = 1'b0;
               step_in    = STEP_W'(WORD_W - 1);
               neg_in     = 1'b0;
               pre0_in    = CH_ZERO;
               pre1_in    = CH_B;
               pre_two_in = 1'b1;
               wide_in    = 1'b1;
               cnt_in     = CNT_W'(NUM_DEC);
               sr_in      = '0;
               bin_in     = req_item.word_value;
               case (req_item.format_code)
                  FMT_BIN: begin
                     sr_in    = {req_item.word_value, (BCD_W - WORD_W)'(0)};
                     wide_in  = 1'b0;
                     cnt_in   = CNT_W'(WORD_W);
                     state_in = ST_PRE;
                  end
                  FMT_HEX: begin
                     sr_in    = {req_item.word_value, (BCD_W - WORD_W)'(0)};
                     cnt_in   = CNT_W'(WORD_W / 4);
                     pre1_in  = CH_X;
                     state_in = ST_PRE;
                  end
                  FMT_SDEC: begin
                     // negate through two's complement; the most negative
                     // value maps onto itself, read as unsigned
                     neg_in     = req_item.word_value[WORD_W-1];
                     bin_in     = abs_word;
                     pre0_in    = CH_MINUS;
                     pre_two_in = 1'b0;
                     state_in   = ST_CONV;
                  end
                  FMT_UDEC: begin
                     state_in = ST_CONV;
                  end
                  FMT_SWAP: begin
                     bin_in   = swap_word;
                     state_in = ST_CONV;
                  end
                  default: begin
                     // unused code: newline alone
                     state_in = ST_NL;
                  end
               endcase
            end
         end
         ST_CONV: begin
            sr_in   = sr_next;
            bin_in  = bin_next;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = neg_ff ? ST_PRE : ST_SKIP;
            end
         end
         ST_PRE: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_item  = '{text_char: (pre_idx_ff ? pre1_ff : pre0_ff),
                              is_last: 1'b0};
               pre_idx_in = 1'b1;
               if (!pre_two_ff || pre_idx_ff) begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SKIP: begin
            // keep at least one digit
            if (top_digit == 4'd0 && cnt_ff != CNT_W'(1)) begin
               sr_in  = sr_next;
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_item = '{text_char: digit_char(top_digit), is_last: 1'b0};
               sr_in     = sr_next;
               cnt_in    = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_NL;
               end
            end
         end
         ST_NL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_item = '{text_char: CH_NL, is_last: 1'b1};
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: loads when empty or being taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = emit_item;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff       <= sr_in;
      bin_ff      <= bin_in;
      cnt_ff      <= cnt_in;
      step_ff     <= step_in;
      wide_ff     <= wide_in;
      neg_ff      <= neg_in;
      pre_two_ff  <= pre_two_in;
      pre_idx_ff  <= pre_idx_in;
      pre0_ff     <= pre0_in;
      pre1_ff     <= pre1_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

`default_nettype wire

/* tb/tb_word_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// tb_word_to_ascii_formatter_unit
// Drives words and format codes into the formatter with random gaps on both
// handshakes. A directed table runs first, then about 350 random words. Every
// character is checked against a behavioral formatter, or against typed-in
// text for the easy rows.
// ----------------------------------------------------------------------------

module tb_word_to_ascii_formatter_unit;

   import w2a_pkg::*;

   // codes the block treats as unused: a bare newline comes back
   localparam logic [FMT_W-1:0] FMT_SPARE5 = 3'd5;
   localparam logic [FMT_W-1:0] FMT_SPARE6 = 3'd6;
   localparam logic [FMT_W-1:0] FMT_SPARE7 = 3'd7;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_WORDS = 347;
   localparam int DRAIN_AT     = 170;    // random word where the sender waits for all text
   localparam int TAIL_CYCLES  = 64;     // quiet time after the last character
   localparam int IDLE_LIMIT   = 4000;   // cycles without any handshake
   localparam int MAX_REPORTS  = 10;
   localparam int DIR_N        = 24;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   rsp_item_type pending_text[$];   // characters still owed by the block, oldest first
   int           mismatch_count;
   int           idle_cycles;
   int           stall_left;
   bit           calm;               // no new gaps on either side while set

   word_to_ascii_formatter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // ------------------------------------------------------------------------
   // Directed table. An empty text means the row goes through the predictor;
   // otherwise the text is the whole line, newline included.
   // ------------------------------------------------------------------------
   logic [WORD_W-1:0] dir_word [DIR_N] = '{
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
      32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001,
      32'h0000_00ff, 32'h1234_5678, 32'hdead_beef, 32'h000f_0000, 32'h0000_000a,
      32'h8000_0000, 32'h0000_0000, 32'h1234_5678, 32'hffff_ffff
   };
   logic [FMT_W-1:0] dir_fmt [DIR_N] = '{
      FMT_BIN,  FMT_SDEC, FMT_HEX,  FMT_UDEC, FMT_SWAP,
      FMT_BIN,  FMT_SDEC, FMT_HEX,  FMT_UDEC, FMT_SWAP,
      FMT_SDEC, FMT_SDEC, FMT_BIN,  FMT_BIN,  FMT_SWAP,
      FMT_SWAP, FMT_SWAP, FMT_HEX,  FMT_HEX,  FMT_SDEC,
      FMT_UDEC, FMT_SPARE5, FMT_SPARE6, FMT_SPARE7
   };
   string dir_text [DIR_N] = '{
      "0b0\n", "0\n", "0x0\n", "0\n", "0\n",
      "", "-1\n", "0xffffffff\n", "4294967295\n", "4294967295\n",
      "-2147483648\n", "2147483647\n", "", "0b1\n", "16777216\n",
      "4278190080\n", "", "0xdeadbeef\n", "0xf0000\n", "10\n",
      "2147483648\n", "\n", "\n", "\n"
   };

   // ------------------------------------------------------------------------
   // Clock, 2 time units per period
   // ------------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Gap length: mostly none, often short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Words that hit the interesting digit counts and sign boundaries.
   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 5))
         0: w = $urandom();
         1: w = $urandom_range(0, 99);
         2: w = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
         3: w = $urandom() >> $urandom_range(1, 31);
         4: w = 32'h8000_0000 ^ 32'($urandom_range(0, 3)) ^ ($urandom() >> 30);
         default: w = {8'($urandom_range(0, 255)), 24'h0} | 32'($urandom_range(0, 255));
      endcase
      return w;
   endfunction

   function automatic logic [FMT_W-1:0] pick_format();
      if ($urandom_range(0, 11) == 0) begin
         return FMT_W'($urandom_range(FMT_SPARE5, FMT_SPARE7));
      end
      return FMT_W'($urandom_range(FMT_BIN, FMT_SWAP));
   endfunction

   task automatic add_char(input logic [CHAR_W-1:0] c);
      pending_text.push_back('{text_char: c, is_last: 1'b0});
   endtask

   // ------------------------------------------------------------------------
   // Predictor: appends the text one word should produce to pending_text.
   // ------------------------------------------------------------------------
   task automatic format_word_text(input logic [WORD_W-1:0] w, input logic [FMT_W-1:0] f);
      logic [WORD_W-1:0] v;
      logic [CHAR_W-1:0] digits[10];
      logic [3:0]        d;
      int                n;
      int                bits;
      bit                started;
      case (f)
         FMT_BIN, FMT_HEX: begin
            // prefix, then radix 2 or 16 digits with leading zeros dropped,
            // the units digit always kept
            bits = (f == FMT_BIN) ? 1 : 4;
            add_char(CH_ZERO);
            add_char((f == FMT_BIN) ? CH_B : CH_X);
            started = 1'b0;
            for (int k = WORD_W / bits - 1; k >= 0; k--) begin
               d = 4'((w >> (k * bits)) & ((f == FMT_BIN) ? 32'h1 : 32'hf));
               if (d != 4'd0 || started || k == 0) begin
                  started = 1'b1;
                  add_char((d < 4'd10) ? CH_ZERO + CHAR_W'(d) : CH_LOW_A + CHAR_W'(d - 4'd10));
               end
            end
         end
         FMT_SDEC, FMT_UDEC, FMT_SWAP: begin
            v = w;
            if (f == FMT_SDEC && w[WORD_W-1]) begin
               // magnitude wraps to 0x80000000 for the most negative word
               add_char(CH_MINUS);
               v = -w;
            end
            if (f == FMT_SWAP) begin
               v = {w[7:0], w[15:8], w[23:16], w[31:24]};
            end
            n = 0;
            do begin
               digits[n] = CH_ZERO + CHAR_W'(v % 10);
               v = v / 10;
               n++;
            end while (v != 0);
            while (n > 0) begin
               n--;
               add_char(digits[n]);
            end
         end
         default: ;   // unused code: newline only
      endcase
      pending_text.push_back('{text_char: CH_NL, is_last: 1'b1});
   endtask

   function automatic void report_mismatch(input string what, input logic [CHAR_W-1:0] want_c,
                                           input logic want_l, input rsp_item_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch %0s: expected char %h last %b, got char %h last %b",
                  what, want_c, want_l, got.text_char, got.is_last);
      end
   endfunction

   // Present one word, hold it until taken, then queue its expected text.
   task automatic send_word(input logic [WORD_W-1:0] w, input logic [FMT_W-1:0] f,
                            input string text);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{word_value: w, format_code: f};
      do @(posedge clock); while (req_stall);
      if (text.len() == 0) begin
         format_word_text(w, f);
      end else begin
         for (int k = 0; k < text.len(); k++) begin
            pending_text.push_back('{text_char: text[k], is_last: (k == text.len() - 1)});
         end
      end
   endtask

   // Sender stops and waits until every owed character has come back.
   task automatic drain_text();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_text.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Sender: reset, directed table, random words, then the wind-down.
   // ------------------------------------------------------------------------
   initial begin : sender
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_item       = '0;
      calm           = 1'b0;
      mismatch_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_N; i++) begin
         send_word(dir_word[i], dir_fmt[i], dir_text[i]);
      end
      drain_text();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         // every fourth block of 40 words runs back to back on both sides
         calm = ((i / 40) % 4 == 3);
         if (i == DRAIN_AT) begin
            drain_text();
         end
         send_word(pick_word(), pick_format(), "");
      end

      calm = 1'b0;
      drain_text();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_text.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver stall: random bursts, none started while calm.
   // ------------------------------------------------------------------------
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Checker: each taken character against the oldest owed one.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_text.size() == 0) begin
            report_mismatch("unexpected item", 8'h00, 1'b0, rsp_item);
         end else begin
            want = pending_text.pop_front();
            if (rsp_item.text_char !== want.text_char) begin
               report_mismatch("text_char", want.text_char, want.is_last, rsp_item);
            end
            if (rsp_item.is_last !== want.is_last) begin
               report_mismatch("is_last", want.text_char, want.is_last, rsp_item);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long with no handshake on either side ends the run.
   // ------------------------------------------------------------------------
   initial idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

/* sim.f */
src/w2a_pkg.sv
src/w2a_shift_unit.sv
src/word_to_ascii_formatter_unit.sv
tb/tb_word_to_ascii_formatter_unit.sv
